>>> sv/assert_macros.svh
// assertion macros for the bound property checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define RRBM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rrbm assertion failed");

// next-cycle implication, disabled while reset is asserted
`define RRBM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rrbm assertion failed");

`endif

>>> sv/rrbm_pkg.sv
`timescale 1ns / 1ps

package rrbm_pkg;

	localparam int unsigned ROM_BANKS_DEF = 8;
	localparam int unsigned RAM_BANKS_DEF = 4;

	localparam int unsigned ROM_BANK_AW   = 14;
	localparam int unsigned RAM_BANK_AW   = 13;
	localparam int unsigned ROM_BANK_SIZE = 16384;
	localparam int unsigned RAM_BANK_SIZE = 8192;
	localparam int unsigned ROM_MAX_DEPTH = 131072;
	localparam int unsigned ROM_MAX_BANKS = 8;

	localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
	localparam logic [4:0] ROM_BANK_MASK  = 5'h1F;
	localparam logic [1:0] RAM_BANK_MASK  = 2'h3;
	localparam logic [7:0] DATA_ZERO      = 8'h00;

	typedef enum logic [1:0] {
		ACT_READ  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_LOAD  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_RAM_OFF  = 2'd1,
		ST_UNMAPPED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SRC_NONE = 2'd0,
		SRC_ROM  = 2'd1,
		SRC_RAM  = 2'd2
	} src_t;

	typedef enum logic {
		MAP_CLEAR = 1'b0,
		MAP_RUN   = 1'b1
	} map_state_t;

	typedef struct packed {
		action_t     action;
		logic [15:0] bus_address;
		logic [7:0]  write_data;
		logic [16:0] rom_offset;
	} req_t;

	// memory commands from the controller, addresses at their widest
	typedef struct packed {
		logic        rom_we;
		logic        rom_re;
		logic [16:0] rom_addr;
		logic        ram_we;
		logic        ram_re;
		logic [14:0] ram_addr;
		logic [7:0]  ram_wdata;
		src_t        src;
		status_t     status;
	} mem_cmd_t;

	typedef logic [31:0][4:0] mod_table_t;

	// remainder table for 5-bit values, built by subtraction at elaboration
	function automatic mod_table_t mod_table(input int unsigned n);
		mod_table_t t;
		int unsigned r;
		for (int i = 0; i < 32; i++) begin
			r = i;
			while (r >= n) begin
				r = r - n;
			end
			t[i] = 5'(r);
		end
		return t;
	endfunction

endpackage

>>> sv/rrbm_if.sv
`timescale 1ns / 1ps

interface rrbm_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [15:0] bus_address;
	logic [7:0]  write_data;
	logic [16:0] rom_offset;

	modport source (output valid, action, bus_address, write_data, rom_offset, input ready);
	modport sink (input valid, action, bus_address, write_data, rom_offset, output ready);
endinterface

interface rrbm_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic [1:0] status;

	modport source (output valid, read_data, status, input ready);
	modport sink (input valid, read_data, status, output ready);
endinterface

>>> sv/rrbm_ram.sv
`timescale 1ns / 1ps

module rrbm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/rrbm_ctrl.sv
`timescale 1ns / 1ps

module rrbm_ctrl #(
	parameter int unsigned ROM_BANKS = rrbm_pkg::ROM_BANKS_DEF,
	parameter int unsigned RAM_BANKS = rrbm_pkg::RAM_BANKS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  rrbm_pkg::req_t     item,
	output logic               run,
	output rrbm_pkg::mem_cmd_t cmd
);

	localparam int unsigned ROM_USED  = (ROM_BANKS < rrbm_pkg::ROM_MAX_BANKS) ?
		ROM_BANKS : rrbm_pkg::ROM_MAX_BANKS;
	localparam int unsigned ROM_DEPTH = ROM_USED * rrbm_pkg::ROM_BANK_SIZE;
	localparam int unsigned RAM_DEPTH = RAM_BANKS * rrbm_pkg::RAM_BANK_SIZE;
	localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH);
	localparam logic [RAM_AW-1:0] CLR_LAST = RAM_AW'(RAM_DEPTH - 1);

	localparam rrbm_pkg::mod_table_t ROM_MOD = rrbm_pkg::mod_table(ROM_BANKS);
	localparam rrbm_pkg::mod_table_t RAM_MOD = rrbm_pkg::mod_table(RAM_BANKS);

	rrbm_pkg::map_state_t state_q, state_d;
	logic [RAM_AW-1:0]    clr_q;
	logic                 ram_en_q;
	logic [4:0]           rom_bank_q;
	logic [1:0]           ram_bank_q;

	logic [15:0] a;
	logic        lo_rom, hi_rom, ram_win;
	logic [4:0]  rom_sel;
	logic [4:0]  rom_bank;
	logic [4:0]  ram_bank;
	logic        load_in_range;
	logic        reg_write;

	assign a             = item.bus_address;
	assign lo_rom        = (a[15:14] == 2'b00);
	assign hi_rom        = (a[15:14] == 2'b01);
	assign ram_win       = (a[15:13] == 3'b101);
	// a selection of zero counts as bank one
	assign rom_sel       = (rom_bank_q == 5'd0) ? 5'd1 : rom_bank_q;
	assign rom_bank      = ROM_MOD[rom_sel];
	assign ram_bank      = RAM_MOD[{3'b000, ram_bank_q}];
	assign load_in_range = ({1'b0, item.rom_offset} < 18'(ROM_DEPTH));
	assign reg_write     = accept && (item.action == rrbm_pkg::ACT_WRITE) && (lo_rom || hi_rom);
	assign run           = (state_q == rrbm_pkg::MAP_RUN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrbm_pkg::MAP_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == rrbm_pkg::MAP_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rrbm_pkg::MAP_CLEAR: begin
				if (clr_q == CLR_LAST) begin
					state_d = rrbm_pkg::MAP_RUN;
				end
			end
			rrbm_pkg::MAP_RUN: begin
				state_d = rrbm_pkg::MAP_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_en_q   <= 1'b0;
			rom_bank_q <= '0;
			ram_bank_q <= '0;
		end else if (reg_write) begin
			unique case (a[14:13])
				2'b00: ram_en_q   <= (item.write_data[3:0] == rrbm_pkg::RAM_ENABLE_KEY);
				2'b01: rom_bank_q <= item.write_data[4:0] & rrbm_pkg::ROM_BANK_MASK;
				2'b10: ram_bank_q <= item.write_data[1:0] & rrbm_pkg::RAM_BANK_MASK;
				2'b11: ; // banking mode select, ignored
			endcase
		end
	end

	always_comb begin
		cmd.rom_we    = 1'b0;
		cmd.rom_re    = 1'b0;
		cmd.rom_addr  = {3'b000, a[13:0]};
		cmd.ram_we    = 1'b0;
		cmd.ram_re    = 1'b0;
		cmd.ram_addr  = {ram_bank[1:0], a[12:0]};
		cmd.ram_wdata = item.write_data;
		cmd.src       = rrbm_pkg::SRC_NONE;
		cmd.status    = rrbm_pkg::ST_OK;
		unique case (item.action)
			rrbm_pkg::ACT_READ: begin
				if (lo_rom) begin
					cmd.rom_re = accept;
					cmd.src    = rrbm_pkg::SRC_ROM;
				end else if (hi_rom) begin
					cmd.rom_re   = accept;
					cmd.rom_addr = 17'({rom_bank, a[13:0]});
					cmd.src      = rrbm_pkg::SRC_ROM;
				end else if (ram_win) begin
					if (ram_en_q) begin
						cmd.ram_re = accept;
						cmd.src    = rrbm_pkg::SRC_RAM;
					end else begin
						cmd.status = rrbm_pkg::ST_RAM_OFF;
					end
				end else begin
					cmd.status = rrbm_pkg::ST_UNMAPPED;
				end
			end
			rrbm_pkg::ACT_WRITE: begin
				if (ram_win) begin
					if (ram_en_q) begin
						cmd.ram_we = accept;
					end else begin
						cmd.status = rrbm_pkg::ST_RAM_OFF;
					end
				end else if (!(lo_rom || hi_rom)) begin
					cmd.status = rrbm_pkg::ST_UNMAPPED;
				end
			end
			rrbm_pkg::ACT_LOAD: begin
				// image bytes beyond any reachable bank are dropped
				cmd.rom_we   = accept && load_in_range;
				cmd.rom_addr = item.rom_offset;
			end
			rrbm_pkg::ACT_NONE: ;
		endcase
		// clearing sweep owns the ram write port, no item is taken then
		if (state_q == rrbm_pkg::MAP_CLEAR) begin
			cmd.ram_we    = 1'b1;
			cmd.ram_addr  = 15'(clr_q);
			cmd.ram_wdata = rrbm_pkg::DATA_ZERO;
		end
	end

endmodule

>>> sv/rom_ram_bank_mapper.sv
`timescale 1ns / 1ps
// result path: an accepted item passes the memory read (s1), then the output register
// throughput: one item per cycle while results are taken; state sits in two
// synchronous memories, control registers update at accept
// reset: asynchronous, active low; afterwards a sweep zeroes all RAM_BANKS * 8192
// entries (32768 by default) of the banked ram, one entry a cycle, with no item taken

module rom_ram_bank_mapper #(
	parameter int unsigned ROM_BANKS = rrbm_pkg::ROM_BANKS_DEF,
	parameter int unsigned RAM_BANKS = rrbm_pkg::RAM_BANKS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	rrbm_in_if.sink    req,
	rrbm_out_if.source rsp
);

	localparam int unsigned ROM_USED  = (ROM_BANKS < rrbm_pkg::ROM_MAX_BANKS) ?
		ROM_BANKS : rrbm_pkg::ROM_MAX_BANKS;
	localparam int unsigned ROM_DEPTH = ROM_USED * rrbm_pkg::ROM_BANK_SIZE;
	localparam int unsigned ROM_AW    = $clog2(ROM_DEPTH);
	localparam int unsigned RAM_DEPTH = RAM_BANKS * rrbm_pkg::RAM_BANK_SIZE;
	localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH);

	rrbm_pkg::req_t     item;
	rrbm_pkg::mem_cmd_t cmd;
	logic               run;
	logic               accept;
	logic               out_free;
	logic [7:0]         rom_rdata;
	logic [7:0]         ram_rdata;

	logic               valid_s1;
	rrbm_pkg::src_t     src_s1;
	rrbm_pkg::status_t  status_s1;
	logic               out_valid_q;
	logic [7:0]         read_data_q;
	logic [1:0]         status_q;

	assign item.action      = rrbm_pkg::action_t'(req.action);
	assign item.bus_address = req.bus_address;
	assign item.write_data  = req.write_data;
	assign item.rom_offset  = req.rom_offset;

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = run && (!valid_s1 || out_free);
	assign accept    = req.valid && req.ready;

	rrbm_ctrl #(
		.ROM_BANKS(ROM_BANKS),
		.RAM_BANKS(RAM_BANKS)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.item  (item),
		.run   (run),
		.cmd   (cmd)
	);

	rrbm_ram #(
		.WIDTH(8),
		.DEPTH(ROM_DEPTH)
	) u_rom (
		.clk  (clk),
		.we   (cmd.rom_we),
		.waddr(ROM_AW'(cmd.rom_addr)),
		.wdata(item.write_data),
		.re   (cmd.rom_re),
		.raddr(ROM_AW'(cmd.rom_addr)),
		.rdata(rom_rdata)
	);

	rrbm_ram #(
		.WIDTH(8),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.ram_we),
		.waddr(RAM_AW'(cmd.ram_addr)),
		.wdata(cmd.ram_wdata),
		.re   (cmd.ram_re),
		.raddr(RAM_AW'(cmd.ram_addr)),
		.rdata(ram_rdata)
	);

	// read data holds in the ram while s1 waits, no read is issued then
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			src_s1    <= cmd.src;
			status_s1 <= cmd.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			status_q <= 2'(status_s1);
			unique case (src_s1)
				rrbm_pkg::SRC_ROM:  read_data_q <= rom_rdata;
				rrbm_pkg::SRC_RAM:  read_data_q <= ram_rdata;
				rrbm_pkg::SRC_NONE: read_data_q <= rrbm_pkg::DATA_ZERO;
				default:            read_data_q <= rrbm_pkg::DATA_ZERO;
			endcase
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.read_data = read_data_q;
	assign rsp.status    = status_q;

endmodule

>>> sv/rrbm_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rrbm_props (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] rsp_read_data,
	input logic [1:0] rsp_status
);

	// a stalled result keeps its value
	`RRBM_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready,
		rsp_valid && $stable(rsp_read_data) && $stable(rsp_status))

	// every status code seen is one of the three defined codes
	`RRBM_ASSERT_IMP(a_status_code, clk, arst_n, rsp_valid, rsp_status != 2'd3)

	// a failed access never carries data
	`RRBM_ASSERT_IMP(a_err_no_data, clk, arst_n, rsp_valid && (rsp_status != 2'd0),
		rsp_read_data == 8'h00)

	// a fresh result traces back to an accepted item
	`RRBM_ASSERT_IMP(a_rsp_source, clk, arst_n, $rose(rsp_valid),
		$past(req_valid && req_ready, 2))

endmodule

bind rom_ram_bank_mapper rrbm_props u_rrbm_props (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_read_data(rsp.read_data),
	.rsp_status   (rsp.status)
);

>>> sim/rrbm_checker.sv
`timescale 1ns / 1ps

module rrbm_checker
	import rrbm_pkg::*;
#(
	parameter int unsigned ROM_BANKS = ROM_BANKS_DEF,
	parameter int unsigned RAM_BANKS = RAM_BANKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rrbm_in_if          req,
	rrbm_out_if         rsp,
	output int unsigned fail_count,
	output int unsigned pending
);

	localparam logic [15:0] ROM_SEL_BASE = 16'h2000;
	localparam logic [15:0] BANKED_BASE  = 16'h4000;
	localparam logic [15:0] MODE_BASE    = 16'h6000;
	localparam logic [15:0] UNMAPPED_LO  = 16'h8000;
	localparam logic [15:0] RAM_BASE     = 16'hA000;
	localparam logic [15:0] RAM_TOP      = 16'hC000;

	typedef struct packed {
		logic [7:0] read_data;
		status_t    status;
	} reply_t;

	bit [7:0]    rom_img [0:ROM_MAX_DEPTH-1];
	bit [7:0]    ram_img [0:32767];
	logic        ram_on;
	logic [4:0]  rom_sel;
	logic [1:0]  ram_sel;
	reply_t      replies_due[$];
	reply_t      want;
	int unsigned mismatches = 0;
	int unsigned outstanding = 0;

	assign fail_count = mismatches;
	assign pending    = outstanding;

	function automatic logic [14:0] ram_slot(input logic [15:0] addr);
		return 15'((ram_sel % RAM_BANKS) * RAM_BANK_SIZE + (addr - RAM_BASE));
	endfunction

	// applies one item to the shadow cartridge state and returns the reply it gives
	function automatic reply_t bank_access(input action_t act, input logic [15:0] addr,
			input logic [7:0] data, input logic [16:0] off);
		reply_t      r;
		int unsigned sel;
		int unsigned idx;
		r.read_data = DATA_ZERO;
		r.status    = ST_OK;
		case (act)
			ACT_READ: begin
				if (addr < BANKED_BASE) begin
					r.read_data = rom_img[addr];
				end else if (addr < UNMAPPED_LO) begin
					// bank 0 in the register selects bank 1
					sel = (rom_sel == 5'd0) ? 1 : rom_sel;
					idx = ((sel % ROM_BANKS) * ROM_BANK_SIZE + (addr - BANKED_BASE))
						% ROM_MAX_DEPTH;
					r.read_data = rom_img[idx];
				end else if (addr >= RAM_BASE && addr < RAM_TOP) begin
					if (!ram_on)
						r.status = ST_RAM_OFF;
					else
						r.read_data = ram_img[ram_slot(addr)];
				end else begin
					r.status = ST_UNMAPPED;
				end
			end
			ACT_WRITE: begin
				if (addr < ROM_SEL_BASE) begin
					ram_on = (data[3:0] == RAM_ENABLE_KEY);
				end else if (addr < BANKED_BASE) begin
					rom_sel = data[4:0] & ROM_BANK_MASK;
				end else if (addr < MODE_BASE) begin
					ram_sel = data[1:0] & RAM_BANK_MASK;
				end else if (addr < UNMAPPED_LO) begin
					// mode select, no effect
				end else if (addr >= RAM_BASE && addr < RAM_TOP) begin
					if (!ram_on)
						r.status = ST_RAM_OFF;
					else
						ram_img[ram_slot(addr)] = data;
				end else begin
					r.status = ST_UNMAPPED;
				end
			end
			ACT_LOAD: begin
				rom_img[off] = data;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			foreach (ram_img[i])
				ram_img[i] = 8'h00;
			ram_on  = 1'b0;
			rom_sel = 5'd0;
			ram_sel = 2'd0;
			replies_due.delete();
			outstanding = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (replies_due.size() == 0) begin
					$error("unexpected item: read_data %0h, status %0d", rsp.read_data,
						rsp.status);
					mismatches++;
				end else begin
					want = replies_due.pop_front();
					if (rsp.read_data !== want.read_data) begin
						$error("read_data mismatch: expected %0h, actual %0h",
							want.read_data, rsp.read_data);
						mismatches++;
					end
					if (rsp.status !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							want.status, rsp.status);
						mismatches++;
					end
				end
			end
			if (req.valid && req.ready)
				replies_due.push_back(bank_access(action_t'(req.action), req.bus_address,
					req.write_data, req.rom_offset));
			outstanding = replies_due.size();
		end
	end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
	import rrbm_pkg::*;

	localparam int unsigned ROM_BANKS = ROM_BANKS_DEF;
	localparam int unsigned RAM_BANKS = RAM_BANKS_DEF;

	localparam logic [15:0] ROM_SEL_BASE = 16'h2000;
	localparam logic [15:0] BANKED_BASE  = 16'h4000;
	localparam logic [15:0] MODE_BASE    = 16'h6000;
	localparam logic [15:0] UNMAPPED_LO  = 16'h8000;
	localparam logic [15:0] RAM_BASE     = 16'hA000;
	localparam logic [15:0] RAM_TOP      = 16'hC000;

	logic        clk = 1'b0;
	logic        arst_n;
	bit          calm = 1'b0;
	int unsigned fails;
	int unsigned pending;
	int unsigned work_done = 0;

	// stimulus bookkeeping: which rom bytes exist, where the bank register points, recent ram writes
	bit          loaded [0:ROM_MAX_DEPTH-1];
	int unsigned rom_filled[$];
	logic [4:0]  bank_reg = 5'd0;
	logic [15:0] ram_marks[$];

	rrbm_in_if  req_ch ();
	rrbm_out_if rsp_ch ();

	rom_ram_bank_mapper #(
		.ROM_BANKS(ROM_BANKS),
		.RAM_BANKS(RAM_BANKS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	rrbm_checker #(
		.ROM_BANKS(ROM_BANKS),
		.RAM_BANKS(RAM_BANKS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.fail_count(fails),
		.pending(pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 7);
	end

	task automatic put_item(input action_t act, input logic [15:0] addr,
			input logic [7:0] data, input logic [16:0] off);
		while (!calm && $urandom_range(0, 99) < 7) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.action      <= act;
		req_ch.bus_address <= addr;
		req_ch.write_data  <= data;
		req_ch.rom_offset  <= off;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		if (act == ACT_LOAD && !loaded[off]) begin
			loaded[off] = 1'b1;
			rom_filled.push_back(off);
		end
		if (act == ACT_WRITE && addr >= ROM_SEL_BASE && addr < BANKED_BASE)
			bank_reg = data[4:0];
		if (act != ACT_NONE && !(act == ACT_WRITE && addr >= MODE_BASE && addr < UNMAPPED_LO))
			work_done++;
	endtask

	// read a loaded rom byte, switching the bank first when the window is elsewhere
	task automatic rom_read();
		int unsigned off;
		int unsigned b;
		int unsigned cur;
		int unsigned v;
		if (rom_filled.size() == 0)
			return;
		off = rom_filled[$urandom_range(0, rom_filled.size() - 1)];
		if (off < ROM_BANK_SIZE && $urandom_range(0, 1)) begin
			put_item(ACT_READ, 16'(off), 8'($urandom), 17'($urandom));
		end else begin
			b   = off / ROM_BANK_SIZE;
			cur = ((bank_reg == 5'd0) ? 1 : bank_reg) % ROM_BANKS;
			if (cur != b) begin
				v = b + ROM_BANKS * $urandom_range(0, (31 - b) / ROM_BANKS);
				if (v == 0)
					v = ROM_BANKS;
				put_item(ACT_WRITE, 16'($urandom_range(ROM_SEL_BASE, BANKED_BASE - 1)),
					{3'($urandom), 5'(v)}, 17'($urandom));
			end
			put_item(ACT_READ, 16'(BANKED_BASE + off % ROM_BANK_SIZE), 8'($urandom),
				17'($urandom));
		end
	endtask

	initial begin
		int unsigned pick;
		int unsigned base;
		logic [15:0] a;
		req_ch.valid       <= 1'b0;
		req_ch.action      <= ACT_READ;
		req_ch.bus_address <= 16'h0000;
		req_ch.write_data  <= 8'h00;
		req_ch.rom_offset  <= 17'h00000;
		arst_n             <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: ram off at reset, rom extremes, bank zero aliasing, masking
		put_item(ACT_READ, RAM_BASE, 8'h00, 17'h00000);
		put_item(ACT_WRITE, 16'(RAM_TOP - 1), 8'hFF, 17'h1FFFF);
		put_item(ACT_LOAD, 16'hFFFF, 8'hFF, 17'h00000);
		put_item(ACT_LOAD, 16'h0000, 8'h5A, 17'h1FFFF);
		put_item(ACT_LOAD, 16'h0000, 8'h3C, 17'h03FFF);
		put_item(ACT_LOAD, 16'h0000, 8'hA5, 17'h04000);
		put_item(ACT_READ, 16'h0000, 8'hFF, 17'h1FFFF);
		put_item(ACT_READ, 16'(BANKED_BASE - 1), 8'h00, 17'h00000);
		put_item(ACT_READ, BANKED_BASE, 8'h00, 17'h00000);
		put_item(ACT_WRITE, ROM_SEL_BASE, 8'hE7, 17'h00000);
		put_item(ACT_READ, 16'(UNMAPPED_LO - 1), 8'h00, 17'h00000);
		put_item(ACT_WRITE, 16'(BANKED_BASE - 1), 8'h08, 17'h00000);
		put_item(ACT_READ, BANKED_BASE, 8'h00, 17'h00000);
		put_item(ACT_WRITE, 16'(ROM_SEL_BASE - 1), 8'hFA, 17'h00000);
		put_item(ACT_WRITE, 16'(MODE_BASE - 1), 8'hFF, 17'h00000);
		put_item(ACT_WRITE, 16'(RAM_TOP - 1), 8'hC3, 17'h00000);
		put_item(ACT_READ, 16'(RAM_TOP - 1), 8'h00, 17'h00000);
		put_item(ACT_WRITE, BANKED_BASE, 8'h00, 17'h00000);
		put_item(ACT_READ, RAM_BASE, 8'h00, 17'h00000);
		put_item(ACT_WRITE, MODE_BASE, 8'hFF, 17'h1FFFF);
		put_item(ACT_READ, UNMAPPED_LO, 8'h00, 17'h00000);
		put_item(ACT_WRITE, 16'hFFFF, 8'hFF, 17'h00000);
		put_item(ACT_NONE, 16'hFFFF, 8'hFF, 17'h1FFFF);
		put_item(ACT_WRITE, 16'h0000, 8'h0B, 17'h00000);
		put_item(ACT_READ, RAM_BASE, 8'h00, 17'h00000);

		work_done = 0;
		while (work_done < 1000) begin
			calm = (work_done >= 300 && work_done < 550);
			pick = $urandom_range(0, 99);
			if (pick < 20) begin
				base = $urandom_range(0, ROM_MAX_DEPTH - 1);
				repeat ($urandom_range(1, 6)) begin
					put_item(ACT_LOAD, 16'($urandom), 8'($urandom), 17'(base));
					base = (base + 1) % ROM_MAX_DEPTH;
				end
			end else if (pick < 40) begin
				repeat ($urandom_range(1, 4))
					rom_read();
			end else if (pick < 65) begin
				// well-formed ram session: enable, maybe pick a bank, then traffic, at times a closing enable write
				put_item(ACT_WRITE, 16'($urandom_range(0, ROM_SEL_BASE - 1)),
					{4'($urandom), RAM_ENABLE_KEY}, 17'($urandom));
				if ($urandom_range(0, 1))
					put_item(ACT_WRITE, 16'($urandom_range(BANKED_BASE, MODE_BASE - 1)),
						8'($urandom), 17'($urandom));
				repeat ($urandom_range(2, 8)) begin
					if (ram_marks.size() > 0 && $urandom_range(0, 1))
						a = ram_marks[$urandom_range(0, ram_marks.size() - 1)];
					else
						a = 16'($urandom_range(RAM_BASE, RAM_TOP - 1));
					if ($urandom_range(0, 2) == 0) begin
						put_item(ACT_READ, a, 8'($urandom), 17'($urandom));
					end else begin
						put_item(ACT_WRITE, a, 8'($urandom), 17'($urandom));
						ram_marks.push_back(a);
						if (ram_marks.size() > 32)
							void'(ram_marks.pop_front());
					end
				end
				if ($urandom_range(0, 3) == 0)
					put_item(ACT_WRITE, 16'($urandom_range(0, ROM_SEL_BASE - 1)),
						8'($urandom), 17'($urandom));
			end else if (pick < 75) begin
				put_item(ACT_WRITE, 16'($urandom_range(0, ROM_SEL_BASE - 1)), 8'($urandom),
					17'($urandom));
				repeat ($urandom_range(1, 3))
					put_item($urandom_range(0, 1) ? ACT_READ : ACT_WRITE,
						16'($urandom_range(RAM_BASE, RAM_TOP - 1)), 8'($urandom),
						17'($urandom));
			end else if (pick < 85) begin
				put_item(ACT_WRITE, 16'($urandom_range(0, UNMAPPED_LO - 1)), 8'($urandom),
					17'($urandom));
			end else if (pick < 95) begin
				a = $urandom_range(0, 1) ? 16'($urandom_range(UNMAPPED_LO, RAM_BASE - 1))
					: 16'($urandom_range(RAM_TOP, 16'hFFFF));
				put_item($urandom_range(0, 1) ? ACT_READ : ACT_WRITE, a, 8'($urandom),
					17'($urandom));
			end else begin
				put_item(ACT_NONE, 16'($urandom), 8'($urandom), 17'($urandom));
			end
		end
		calm = 1'b0;
		req_ch.valid <= 1'b0;

		do
			@(posedge clk);
		while (pending != 0);
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("rom_ram_bank_mapper verification clean");
		else
			$display("rom_ram_bank_mapper verification failed");
		$finish;
	end

	// time limit that fails the run; it covers the ram clearing sweep after reset several times over
	initial begin
		#(5_000_000);
		$display("rom_ram_bank_mapper verification failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+sv
sv/rrbm_pkg.sv
sv/rrbm_if.sv
sv/rrbm_ram.sv
sv/rrbm_ctrl.sv
sv/rom_ram_bank_mapper.sv
sv/rrbm_checker.sv
sim/rrbm_checker.sv
sim/tb.sv
